// ----- hdl/nan_aware_column_interpolator_macros.svh -----
// ----------------------------------------------------------------------------
// NaN-aware column interpolator: assertion macros
// Concurrent checks clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NAN_AWARE_COLUMN_INTERPOLATOR_MACROS_SVH
`define NAN_AWARE_COLUMN_INTERPOLATOR_MACROS_SVH

`ifndef SYNTHESIS

// Full property, clocked and disabled during reset.
`define NCI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication from a condition to a consequence.
`define NCI_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define NCI_ASSERT(name, prop, msg)
`define NCI_ASSERT_IMPL(name, ante, cons, msg)

`endif

`endif

// ----- hdl/nci_pkg.sv -----
// ----------------------------------------------------------------------------
// nci_pkg
// Shared widths, limits and the request and response bundles of the
// multiply-divide unit.
// ----------------------------------------------------------------------------
package nci_pkg;

  localparam int IDX_W     = 14;
  localparam int DATA_W    = 32;
  localparam int MAX_ROWS  = 16384;
  localparam int ROW_LIMIT = (MAX_ROWS - 1 > 2) ? (MAX_ROWS - 1) : 2;

  // The divider produces one quotient bit per cycle.
  localparam int DIV_STEPS = DATA_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] multiplicand;
    logic [DATA_W-1:0] multiplier;
    logic [DATA_W-1:0] divisor;
  } md_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
  } md_rsp_t;

endpackage

// ----- hdl/nci_muldiv.sv -----
// ----------------------------------------------------------------------------
// nci_muldiv
// Computes floor(a * b / d) for unsigned operands with b <= d: a multiply
// state, then a restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "nan_aware_column_interpolator_macros.svh"

module nci_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nci_pkg::md_req_t req_i,
  output nci_pkg::md_rsp_t rsp_o
);
  import nci_pkg::*;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  md_state_e         state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [DATA_W-1:0] a_q, b_q, d_q;
  logic [DATA_W-1:0] rem_q, quo_q;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = trial >= {1'b0, d_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      MD_IDLE: if (req_i.start) state_d = MD_MUL;
      MD_MUL:  state_d = MD_DIV;
      MD_DIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == MD_DIV) && (cnt_q == CNT_W'(DIV_STEPS - 1));
      case (state_q)
        MD_MUL:  cnt_q <= '0;
        MD_DIV:  cnt_q <= cnt_q + CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          a_q <= req_i.multiplicand;
          b_q <= req_i.multiplier;
          d_q <= req_i.divisor;
        end
      end
      MD_MUL: begin
        {rem_q, quo_q} <= {{DATA_W{1'b0}}, a_q} * {{DATA_W{1'b0}}, b_q};
      end
      MD_DIV: begin
        rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], ge};
      end
      default: begin
        rem_q <= rem_q;
      end
    endcase
  end

  assign rsp_o.busy     = (state_q != MD_IDLE);
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `NCI_ASSERT_IMPL(a_start_idle, req_i.start, state_q == MD_IDLE, "start while unit busy")
  `NCI_ASSERT_IMPL(a_quot_bound, done_q, quo_q <= a_q, "quotient exceeds multiplicand")
  `NCI_ASSERT(a_done_pulse, done_q |=> !done_q, "done held longer than one cycle")

endmodule

// ----- hdl/nan_aware_column_interpolator.sv -----
// ----------------------------------------------------------------------------
// nan_aware_column_interpolator
// Streams one latitude-sorted column and fills missing samples from
// neighbour averages, interpolating by latitude where the row lies between.
// ----------------------------------------------------------------------------
// Operation: a row that needs latitude interpolation also passes through the
//   shared unit, which multiplies and then divides; any other row skips it.
// Throughput: one row at a time, in_stall_o high until the row is finished;
//   a row finishes later while the output word is stalled.
// Reset: rst_ni clears the sequencer, the output valid and all column state.
// ----------------------------------------------------------------------------
`include "nan_aware_column_interpolator_macros.svh"

module nan_aware_column_interpolator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic        [nci_pkg::IDX_W-1:0]    sort_index_i,
  input  logic signed [nci_pkg::DATA_W-1:0]   latitude_i,
  input  logic signed [nci_pkg::DATA_W-1:0]   sample_value_i,
  input  logic                                sample_valid_i,
  input  logic                                last_in_column_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [nci_pkg::IDX_W-1:0]    row_number_o,
  output logic signed [nci_pkg::DATA_W-1:0]   result_value_o,
  output logic                                result_valid_o,
  output logic                                column_done_o
);
  import nci_pkg::*;

  // Sequencer. Each row walks through these steps; the middle-row steps are
  // skipped for the first two rows of a column.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,  // waiting for a row
    S_ROW0  = 8'b0000_0010,  // row 0 word or single-row column word
    S_MID1  = 8'b0000_0100,  // pair means of latitude and value
    S_MID2  = 8'b0000_1000,  // pick the rule for the held row
    S_START = 8'b0001_0000,  // hand the interpolation to the shared unit
    S_WAIT  = 8'b0010_0000,  // shared unit multiplying and dividing
    S_MOUT  = 8'b0100_0000,  // middle row word
    S_FIN   = 8'b1000_0000   // final row word or shift of the row window
  } state_e;

  state_e state_q, state_d;

  // The accepted row.
  logic        [IDX_W-1:0]  x_sidx_q;
  logic signed [DATA_W-1:0] x_lat_q, x_val_q;
  logic                     x_ok_q, x_last_q;

  // Column state: the row before the held row, the held row, and bookkeeping.
  logic        [IDX_W-1:0]  row_cnt_q;
  logic signed [DATA_W-1:0] prev_lat_q, prev_val_q;
  logic                     prev_ok_q;
  logic signed [DATA_W-1:0] held_lat_q, held_val_q;
  logic                     held_ok_q;
  logic        [IDX_W-1:0]  held_sidx_q;
  logic                     first_done_q;
  logic signed [DATA_W-1:0] latest_q;

  // Middle-row working registers.
  logic signed [DATA_W-1:0] x1_q, x2_q, y1_q, y2_q;
  logic                     y1ok_q, y2ok_q, pass_q, nodata_q;
  logic signed [DATA_W-1:0] mid_val_q;
  logic                     mid_ok_q, interp_q;
  logic signed [DATA_W:0]   dy_q, num_q, den_q;

  // Output register.
  logic                     out_valid_q;
  logic        [IDX_W-1:0]  out_row_q;
  logic signed [DATA_W-1:0] out_val_q;
  logic                     out_ok_q, out_done_q;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic in_accept, out_free;
  logic load, ld_ok, ld_done;
  logic        [IDX_W-1:0]  ld_row;
  logic signed [DATA_W-1:0] ld_val;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // The output register can take a new word when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;

  // Pair means. Every mean is a floor division by two, so an arithmetic
  // shift of the 33-bit sum.
  logic signed [DATA_W:0] sum_x1, sum_x2, sum_hp, sum_hx, sum_y;
  logic signed [DATA_W-1:0] y1_c, y2_c;

  assign sum_x1 = $signed({held_lat_q[DATA_W-1], held_lat_q})
                + $signed({prev_lat_q[DATA_W-1], prev_lat_q});
  assign sum_x2 = $signed({held_lat_q[DATA_W-1], held_lat_q})
                + $signed({x_lat_q[DATA_W-1], x_lat_q});
  assign sum_hp = $signed({held_val_q[DATA_W-1], held_val_q})
                + $signed({prev_val_q[DATA_W-1], prev_val_q});
  assign sum_hx = $signed({held_val_q[DATA_W-1], held_val_q})
                + $signed({x_val_q[DATA_W-1], x_val_q});
  assign sum_y  = $signed({y1_q[DATA_W-1], y1_q}) + $signed({y2_q[DATA_W-1], y2_q});

  always_comb begin
    if (held_ok_q && prev_ok_q) begin
      y1_c = sum_hp[DATA_W:1];
    end else if (held_ok_q) begin
      y1_c = held_val_q;
    end else if (prev_ok_q) begin
      y1_c = prev_val_q;
    end else begin
      y1_c = '0;
    end
    if (held_ok_q && x_ok_q) begin
      y2_c = sum_hx[DATA_W:1];
    end else if (held_ok_q) begin
      y2_c = held_val_q;
    end else if (x_ok_q) begin
      y2_c = x_val_q;
    end else begin
      y2_c = '0;
    end
  end

  // Rule selection for the held row, from the registered means.
  logic between, interp_c;

  assign between  = ((x1_q <= held_lat_q) && (held_lat_q <= x2_q))
                 || ((x2_q <= held_lat_q) && (held_lat_q <= x1_q));
  assign interp_c = !pass_q && !nodata_q && y1ok_q && y2ok_q
                 && (x1_q != x2_q) && between;

  // Operands of the shared unit: magnitudes of the value step, of the
  // latitude offset and of the latitude span. The row lies between the two
  // means, so the offset never exceeds the span and the quotient stays
  // within the value step.
  logic signed [DATA_W:0] dy_abs, num_abs, den_abs;

  assign dy_abs  = dy_q[DATA_W]  ? -dy_q  : dy_q;
  assign num_abs = num_q[DATA_W] ? -num_q : num_q;
  assign den_abs = den_q[DATA_W] ? -den_q : den_q;

  assign md_req.start        = (state_q == S_START);
  assign md_req.multiplicand = dy_abs[DATA_W-1:0];
  assign md_req.multiplier   = num_abs[DATA_W-1:0];
  assign md_req.divisor      = den_abs[DATA_W-1:0];

  nci_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Interpolated value: y1 plus the quotient, which takes the sign of the
  // value step (truncation toward zero).
  logic signed [DATA_W:0]   q_ext, interp_sum;
  logic signed [DATA_W-1:0] mid_value;

  assign q_ext      = $signed({1'b0, md_rsp.quotient});
  assign interp_sum = $signed({y1_q[DATA_W-1], y1_q}) + (dy_q[DATA_W] ? -q_ext : q_ext);
  assign mid_value  = interp_q ? interp_sum[DATA_W-1:0] : mid_val_q;

  logic row0_emit;
  state_e after_row0;

  // Row 0 is reported on the first valid non-final row, or as zero when the
  // final row comes before any valid sample.
  assign row0_emit  = !first_done_q && (x_last_q || x_ok_q);
  assign after_row0 = (row_cnt_q >= IDX_W'(2)) ? S_MID1 : S_FIN;

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    ld_row  = '0;
    ld_val  = '0;
    ld_ok   = 1'b0;
    ld_done = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_ROW0;
      end
      S_ROW0: begin
        if (x_last_q && (row_cnt_q == '0)) begin
          // Single-row column: this row is both row 0 and the final row.
          if (out_free) begin
            load    = 1'b1;
            ld_val  = latest_q;
            ld_ok   = 1'b1;
            ld_done = 1'b1;
            state_d = S_IDLE;
          end
        end else if (row0_emit) begin
          if (out_free) begin
            load    = 1'b1;
            ld_val  = x_last_q ? '0 : x_val_q;
            ld_ok   = 1'b1;
            state_d = after_row0;
          end
        end else begin
          state_d = after_row0;
        end
      end
      S_MID1: begin
        state_d = S_MID2;
      end
      S_MID2: begin
        state_d = interp_c ? S_START : S_MOUT;
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (md_rsp.done) state_d = S_MOUT;
      end
      S_MOUT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_row  = row_cnt_q - IDX_W'(1);
          ld_val  = mid_value;
          ld_ok   = mid_ok_q;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (x_last_q) begin
          if (out_free) begin
            load    = 1'b1;
            ld_row  = row_cnt_q;
            ld_val  = latest_q;
            ld_ok   = 1'b1;
            ld_done = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A column ends when its final word is loaded; all column state goes back
  // to its reset value for the next column.
  logic clear_col;

  assign clear_col = load && ld_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      row_cnt_q    <= '0;
      prev_lat_q   <= '0;
      prev_val_q   <= '0;
      prev_ok_q    <= 1'b0;
      held_lat_q   <= '0;
      held_val_q   <= '0;
      held_ok_q    <= 1'b0;
      held_sidx_q  <= '0;
      first_done_q <= 1'b0;
      latest_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_accept && sample_valid_i) begin
        latest_q <= sample_value_i;
      end

      if (clear_col) begin
        row_cnt_q    <= '0;
        prev_lat_q   <= '0;
        prev_val_q   <= '0;
        prev_ok_q    <= 1'b0;
        held_lat_q   <= '0;
        held_val_q   <= '0;
        held_ok_q    <= 1'b0;
        held_sidx_q  <= '0;
        first_done_q <= 1'b0;
        latest_q     <= '0;
      end else if ((state_q == S_ROW0) && load) begin
        first_done_q <= 1'b1;
      end else if ((state_q == S_FIN) && !x_last_q) begin
        // Slide the three-row window and count the row, saturating.
        prev_lat_q  <= held_lat_q;
        prev_val_q  <= held_val_q;
        prev_ok_q   <= held_ok_q;
        held_lat_q  <= x_lat_q;
        held_val_q  <= x_val_q;
        held_ok_q   <= x_ok_q;
        held_sidx_q <= x_sidx_q;
        if (row_cnt_q < IDX_W'(ROW_LIMIT)) begin
          row_cnt_q <= row_cnt_q + IDX_W'(1);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_sidx_q <= sort_index_i;
      x_lat_q  <= latitude_i;
      x_val_q  <= sample_value_i;
      x_ok_q   <= sample_valid_i;
      x_last_q <= last_in_column_i;
    end

    if (state_q == S_MID1) begin
      x1_q     <= sum_x1[DATA_W:1];
      x2_q     <= sum_x2[DATA_W:1];
      y1_q     <= y1_c;
      y2_q     <= y2_c;
      y1ok_q   <= held_ok_q || prev_ok_q;
      y2ok_q   <= held_ok_q || x_ok_q;
      pass_q   <= held_ok_q && (x_sidx_q > held_sidx_q);
      nodata_q <= !held_ok_q && !prev_ok_q && !x_ok_q;
    end

    if (state_q == S_MID2) begin
      interp_q <= interp_c;
      mid_ok_q <= !(nodata_q && !pass_q);
      if (pass_q) begin
        mid_val_q <= held_val_q;
      end else if (nodata_q) begin
        mid_val_q <= '0;
      end else if (!y1ok_q) begin
        mid_val_q <= y2_q;
      end else if (!y2ok_q) begin
        mid_val_q <= y1_q;
      end else begin
        mid_val_q <= sum_y[DATA_W:1];
      end
      dy_q  <= $signed({y2_q[DATA_W-1], y2_q}) - $signed({y1_q[DATA_W-1], y1_q});
      num_q <= $signed({held_lat_q[DATA_W-1], held_lat_q})
             - $signed({x1_q[DATA_W-1], x1_q});
      den_q <= $signed({x2_q[DATA_W-1], x2_q}) - $signed({x1_q[DATA_W-1], x1_q});
    end

    if (load) begin
      out_row_q  <= ld_row;
      out_val_q  <= ld_val;
      out_ok_q   <= ld_ok;
      out_done_q <= ld_done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign row_number_o   = out_row_q;
  assign result_value_o = out_val_q;
  assign result_valid_o = out_ok_q;
  assign column_done_o  = out_done_q;

  `NCI_ASSERT(a_done_clears, clear_col |=> (row_cnt_q == '0) && !first_done_q, "column kept")
  `NCI_ASSERT_IMPL(a_row0_once, load && (ld_row == '0) && !ld_done, !first_done_q, "row 0 twice")
  `NCI_ASSERT_IMPL(a_div_nonzero, state_q == S_START, (den_q != '0) && interp_q, "zero span")
  `NCI_ASSERT_IMPL(a_wait_busy, (state_q == S_WAIT) && !md_rsp.done, md_rsp.busy, "unit idle")

endmodule
